>>> hdl/mfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_pkg: shared types and constants of the meter frame deframer
// Frame layout positions, status codes, CRC-16 and BCD helpers.
// ----------------------------------------------------------------------------
package mfd_pkg;

   // frame layout
   localparam int ID_BYTES       = 5;
   localparam int MAX_VALUE_SIZE = 10;
   localparam int SIZE_POS       = 2 + ID_BYTES;
   localparam int IDX_POS        = SIZE_POS + 1;
   localparam int VAL_POS        = SIZE_POS + 3;
   localparam int FRAME_DEPTH    = VAL_POS + MAX_VALUE_SIZE;

   localparam int CNT_W  = $clog2(FRAME_DEPTH + 1);
   localparam int SIZE_W = $clog2(MAX_VALUE_SIZE + 1);

   localparam logic [15:0] CRC_POLY        = 16'hA001;
   localparam logic [15:0] TIMEOUT_DEFAULT = 16'd500;

   // register indexes of the CSR port
   typedef enum logic {
      CSR_PREAMBLE = 1'b0,
      CSR_TIMEOUT  = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_PREAMBLE = 3'd1,
      ST_SIZE     = 3'd2,
      ST_CRC      = 3'd3,
      ST_TIMEOUT  = 3'd4
   } status_type;

   typedef struct packed {
      logic [15:0] preamble_word;
      logic [15:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] meter_id;
      logic [15:0] register_index;
      logic [31:0] reading_value;
   } result_type;

   // CRC-16, reflected, one byte
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   // two BCD digits, nibbles unchecked: 10*high + low, at most 165
   function automatic logic [7:0] bcd_pair(input logic [7:0] b);
      return {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'h0, b[3:0]};
   endfunction

   // acc*100 + pair, modulo 2^32, as shift-adds
   function automatic logic [31:0] bcd_shift(input logic [31:0] acc, input logic [7:0] b);
      return (acc << 6) + (acc << 5) + (acc << 2) + {24'h0, bcd_pair(b)};
   endfunction

endpackage

>>> hdl/mfd_frame_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_frame_engine: frame state and per-request decode
// Updates CRC, BCD accumulators and counters for one request per step.
// ----------------------------------------------------------------------------
module mfd_frame_engine
   import mfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       func,
   input  logic [7:0] byte_value,
   input  cfg_type    cfg,
   output logic       res_valid,
   output result_type res
);

   logic [CNT_W-1:0]  byte_count_ff, byte_count_in;
   logic [SIZE_W-1:0] declared_size_ff, declared_size_in;
   logic [15:0]       running_crc_ff, running_crc_in;
   logic [31:0]       id_acc_ff, id_acc_in;
   logic [31:0]       value_acc_ff, value_acc_in;
   logic [15:0]       idle_ticks_ff, idle_ticks_in;
   // only the frame bytes ever read back are kept
   logic [7:0]        prev_byte_ff, prev_byte_in;
   logic [7:0]        idx_lo_ff, idx_lo_in;
   logic [7:0]        idx_hi_ff, idx_hi_in;

   logic [CNT_W:0]    p_ext, end_pos;
   logic              in_crc, in_id, in_val;
   logic [15:0]       crc_new;
   logic [31:0]       id_new, val_new;
   logic [15:0]       idle_inc;
   logic              clear;

   always_comb begin
      p_ext   = {1'b0, byte_count_ff};
      end_pos = (CNT_W + 1)'(VAL_POS) + {{(CNT_W + 1 - SIZE_W){1'b0}}, declared_size_ff};
      in_crc  = (p_ext >= 2) && ((p_ext <= (CNT_W + 1)'(SIZE_POS)) || (p_ext + 2 < end_pos));
      in_id   = (p_ext >= 2) && (p_ext < (CNT_W + 1)'(2 + ID_BYTES));
      in_val  = (p_ext >= (CNT_W + 1)'(VAL_POS)) && (p_ext + 2 < end_pos);
      crc_new = in_crc ? crc_byte(running_crc_ff, byte_value) : running_crc_ff;
      id_new  = in_id  ? bcd_shift(id_acc_ff, byte_value)     : id_acc_ff;
      val_new = in_val ? bcd_shift(value_acc_ff, byte_value)  : value_acc_ff;
      idle_inc = (idle_ticks_ff == 16'hFFFF) ? idle_ticks_ff : idle_ticks_ff + 16'd1;

      byte_count_in    = byte_count_ff;
      declared_size_in = declared_size_ff;
      running_crc_in   = running_crc_ff;
      id_acc_in        = id_acc_ff;
      value_acc_in     = value_acc_ff;
      idle_ticks_in    = idle_ticks_ff;
      prev_byte_in     = prev_byte_ff;
      idx_lo_in        = idx_lo_ff;
      idx_hi_in        = idx_hi_ff;
      clear            = 1'b0;
      res_valid        = 1'b0;
      res              = '0;
      res.status       = ST_OK;

      if (step && func) begin
         // tick: only counts while a frame is pending
         if (byte_count_ff != '0) begin
            idle_ticks_in = idle_inc;
            if (idle_inc >= cfg.timeout_ticks) begin
               clear      = 1'b1;
               res_valid  = 1'b1;
               res.status = ST_TIMEOUT;
            end
         end
      end else if (step) begin
         byte_count_in  = byte_count_ff + 1'b1;
         idle_ticks_in  = '0;
         running_crc_in = crc_new;
         id_acc_in      = id_new;
         value_acc_in   = val_new;
         prev_byte_in   = byte_value;
         if (p_ext == (CNT_W + 1)'(IDX_POS)) begin
            idx_lo_in = byte_value;
         end
         if (p_ext == (CNT_W + 1)'(IDX_POS + 1)) begin
            idx_hi_in = byte_value;
         end

         if (p_ext == 0) begin
            if (byte_value != cfg.preamble_word[7:0]) begin
               clear      = 1'b1;
               res_valid  = 1'b1;
               res.status = ST_PREAMBLE;
            end
         end else if (p_ext == 1) begin
            if ({byte_value, prev_byte_ff} != cfg.preamble_word) begin
               clear      = 1'b1;
               res_valid  = 1'b1;
               res.status = ST_PREAMBLE;
            end
         end else if (p_ext == (CNT_W + 1)'(SIZE_POS)) begin
            if (byte_value > 8'(MAX_VALUE_SIZE)) begin
               clear      = 1'b1;
               res_valid  = 1'b1;
               res.status = ST_SIZE;
            end else begin
               declared_size_in = byte_value[SIZE_W-1:0];
            end
         end else if ((p_ext > (CNT_W + 1)'(SIZE_POS)) && (p_ext + 1 == end_pos)) begin
            clear     = 1'b1;
            res_valid = 1'b1;
            if ({byte_value, prev_byte_ff} != crc_new) begin
               res.status = ST_CRC;
            end else begin
               res.status         = ST_OK;
               res.meter_id       = id_new;
               // short frames end on the index high byte itself
               res.register_index = {(p_ext == (CNT_W + 1)'(IDX_POS + 1)) ? byte_value
                                                                          : idx_hi_ff,
                                     idx_lo_ff};
               res.reading_value  = val_new;
            end
         end
      end

      if (clear) begin
         byte_count_in    = '0;
         declared_size_in = '0;
         running_crc_in   = '0;
         id_acc_in        = '0;
         value_acc_in     = '0;
         idle_ticks_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff    <= '0;
         declared_size_ff <= '0;
         running_crc_ff   <= '0;
         id_acc_ff        <= '0;
         value_acc_ff     <= '0;
         idle_ticks_ff    <= '0;
      end else begin
         byte_count_ff    <= byte_count_in;
         declared_size_ff <= declared_size_in;
         running_crc_ff   <= running_crc_in;
         id_acc_ff        <= id_acc_in;
         value_acc_ff     <= value_acc_in;
         idle_ticks_ff    <= idle_ticks_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_byte_ff <= prev_byte_in;
      idx_lo_ff    <= idx_lo_in;
      idx_hi_ff    <= idx_hi_in;
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff < CNT_W'(FRAME_DEPTH))
      else $error("byte count past frame depth");

   a_size_range: assert property (@(posedge clock) disable iff (reset)
      declared_size_ff <= SIZE_W'(MAX_VALUE_SIZE))
      else $error("declared size above limit");

   a_idle_needs_frame: assert property (@(posedge clock) disable iff (reset)
      idle_ticks_ff != '0 |-> byte_count_ff != '0)
      else $error("idle ticks counted with no frame pending");

   a_result_clears: assert property (@(posedge clock) disable iff (reset)
      res_valid |=> byte_count_ff == '0 && running_crc_ff == '0)
      else $error("frame state not cleared after result");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.status != ST_OK |->
         res.meter_id == '0 && res.register_index == '0 && res.reading_value == '0)
      else $error("error result carries frame fields");
`endif

endmodule

>>> hdl/meter_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meter_frame_deframer: serial meter frame deframer
// Collects bytes into frames, checks preamble, size and CRC-16, converts
// BCD id and value fields, and drops partial frames on idle timeout.
// ----------------------------------------------------------------------------
//
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  req     | req_valid, req_stall, req_func, req_byte_value | in
//  rsp     | rsp_valid, rsp_stall, rsp_status, rsp_meter_id,| out
//          | rsp_register_index, rsp_reading_value          |
//  csr     | csr_write_en, csr_index, csr_wdata             | in
//
//  One request per clock while req_stall is low. A request is held in the
//  input register, the frame engine decodes it in a single pass and any
//  result is registered in the result register, which drives rsp_valid.
//  Synchronous reset clears frame state and loads preamble 0, timeout 500.
//  rsp_stall holds a valid result register; an empty input register still
//  takes one more request, then req_stall rises until the result is taken.
//
module meter_frame_deframer
   import mfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [7:0]  req_byte_value,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_meter_id,
   output logic [15:0] rsp_register_index,
   output logic [31:0] rsp_reading_value,
   // configuration writes
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   // configuration registers
   cfg_type    cfg_ff, cfg_in;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic       in_func_ff;
   logic [7:0] in_byte_ff;

   // result register
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;

   logic       advance;    // input register moves through the engine
   logic       accept;
   logic       eng_valid;
   result_type eng_res;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_PREAMBLE: cfg_in.preamble_word = csr_wdata;
            CSR_TIMEOUT:  cfg_in.timeout_ticks = csr_wdata;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.preamble_word <= '0;
         cfg_ff.timeout_ticks <= TIMEOUT_DEFAULT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // the engine steps only when the result register can take its output
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_func_ff <= req_func;
         in_byte_ff <= req_byte_value;
      end
   end

   mfd_frame_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .func       (in_func_ff),
      .byte_value (in_byte_ff),
      .cfg        (cfg_ff),
      .res_valid  (eng_valid),
      .res        (eng_res)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = eng_valid;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && eng_valid) begin
         out_ff <= eng_res;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = out_ff.status;
   assign rsp_meter_id       = out_ff.meter_id;
   assign rsp_register_index = out_ff.register_index;
   assign rsp_reading_value  = out_ff.reading_value;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |-> !advance)
      else $error("result register overwritten while stalled");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff)
      else $error("request stalled with room in the pipeline");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |=> out_valid_ff && $stable(out_ff))
      else $error("stalled result changed");
`endif

endmodule
